[rtl/cfsm_pkg.sv]
package cfsm_pkg;

  localparam int WordW      = 32;
  localparam int SlotsW     = 7;
  localparam int SlotsReset = 64;

  typedef enum logic [1:0] {
    CMD_PUSH,
    CMD_POP,
    CMD_SEARCH,
    CMD_MAX
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_OVERFLOW,
    ST_UNDERFLOW,
    ST_MAX_EMPTY
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_POP,
    S_SCAN,
    S_HEAD_RD,
    S_FIN
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic    capture;
    logic    dispatch;
    status_t status;
    logic    push_wr;
    logic    pop_rd;
    logic    pop_take;
    logic    scan_start;
    logic    scan_step;
    logic    head_rd;
    logic    out_load;
  } ctl_t;

  // status from datapath to controller
  typedef struct packed {
    cmd_t cmd;
    logic empty;
    logic full;
    logic scan_done;
  } dp_stat_t;

endpackage

[rtl/cfsm_if.sv]
interface cfsm_in_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          cmd;
  logic signed [cfsm_pkg::WordW-1:0]   push_value;
  logic signed [cfsm_pkg::WordW-1:0]   search_key;

  modport source (output valid, output cmd, output push_value, output search_key,
                  input ready);
  modport sink   (input valid, input cmd, input push_value, input search_key,
                  output ready);
endinterface

interface cfsm_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [cfsm_pkg::WordW-1:0]   data_out;
  logic                                found;
  logic signed [cfsm_pkg::WordW-1:0]   head_value;
  logic                                is_empty;
  logic                                is_full;
  logic [1:0]                          status;

  modport source (output valid, output data_out, output found, output head_value,
                  output is_empty, output is_full, output status, input ready);
  modport sink   (input valid, input data_out, input found, input head_value,
                  input is_empty, input is_full, input status, output ready);
endinterface

[rtl/cfsm_ctrl.sv]
module cfsm_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  cfsm_pkg::dp_stat_t stat,
  output cfsm_pkg::ctl_t     ctl
);

  cfsm_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == cfsm_pkg::S_IDLE);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cfsm_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cfsm_pkg::S_IDLE: begin
        if (in_valid) state_nxt = cfsm_pkg::S_DISPATCH;
      end
      cfsm_pkg::S_DISPATCH: begin
        unique case (stat.cmd)
          cfsm_pkg::CMD_PUSH:   state_nxt = cfsm_pkg::S_HEAD_RD;
          cfsm_pkg::CMD_POP:    state_nxt = stat.empty ? cfsm_pkg::S_HEAD_RD : cfsm_pkg::S_POP;
          cfsm_pkg::CMD_SEARCH: state_nxt = cfsm_pkg::S_SCAN;
          cfsm_pkg::CMD_MAX:    state_nxt = stat.empty ? cfsm_pkg::S_HEAD_RD : cfsm_pkg::S_SCAN;
          default:              state_nxt = cfsm_pkg::S_HEAD_RD;
        endcase
      end
      cfsm_pkg::S_POP:     state_nxt = cfsm_pkg::S_HEAD_RD;
      cfsm_pkg::S_SCAN: begin
        if (stat.scan_done) state_nxt = cfsm_pkg::S_HEAD_RD;
      end
      cfsm_pkg::S_HEAD_RD: state_nxt = cfsm_pkg::S_FIN;
      cfsm_pkg::S_FIN: begin
        if (out_free) state_nxt = cfsm_pkg::S_IDLE;
      end
      default:             state_nxt = cfsm_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctl           = '0;
    ctl.status    = cfsm_pkg::ST_OK;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      cfsm_pkg::S_IDLE: ctl.capture = in_valid;
      cfsm_pkg::S_DISPATCH: begin
        ctl.dispatch = 1'b1;
        unique case (stat.cmd)
          cfsm_pkg::CMD_PUSH: begin
            if (stat.full) ctl.status  = cfsm_pkg::ST_OVERFLOW;
            else           ctl.push_wr = 1'b1;
          end
          cfsm_pkg::CMD_POP: begin
            if (stat.empty) ctl.status = cfsm_pkg::ST_UNDERFLOW;
            else            ctl.pop_rd = 1'b1;
          end
          cfsm_pkg::CMD_SEARCH: ctl.scan_start = 1'b1;
          cfsm_pkg::CMD_MAX: begin
            if (stat.empty) ctl.status     = cfsm_pkg::ST_MAX_EMPTY;
            else            ctl.scan_start = 1'b1;
          end
          default: ctl.status = cfsm_pkg::ST_OK;
        endcase
      end
      cfsm_pkg::S_POP:     ctl.pop_take  = 1'b1;
      cfsm_pkg::S_SCAN:    ctl.scan_step = 1'b1;
      cfsm_pkg::S_HEAD_RD: ctl.head_rd   = 1'b1;
      cfsm_pkg::S_FIN: begin
        if (out_free) begin
          ctl.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      default: ctl.status = cfsm_pkg::ST_OK;
    endcase
  end

endmodule

[rtl/cfsm_dp.sv]
module cfsm_dp #(
  parameter int DEPTH = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [cfsm_pkg::SlotsW-1:0]       cfg_data,
  input  logic [1:0]                        in_cmd,
  input  logic signed [cfsm_pkg::WordW-1:0] in_push_value,
  input  logic signed [cfsm_pkg::WordW-1:0] in_search_key,
  input  cfsm_pkg::ctl_t                    ctl,
  output cfsm_pkg::dp_stat_t                stat,
  output logic signed [cfsm_pkg::WordW-1:0] out_data_out,
  output logic                              out_found,
  output logic signed [cfsm_pkg::WordW-1:0] out_head_value,
  output logic                              out_is_empty,
  output logic                              out_is_full,
  output logic [1:0]                        out_status
);

  localparam int AW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam int NW = AW + 1;

  function automatic logic [NW-1:0] clamp_size(input logic [cfsm_pkg::SlotsW-1:0] s);
    int unsigned v;
    v = int'(s);
    if (v < 2) v = 2;
    if (v > DEPTH) v = DEPTH;
    return NW'(v);
  endfunction

  function automatic logic [AW-1:0] advance(input logic [AW-1:0] i, input logic [NW-1:0] n);
    logic [NW-1:0] p;
    p = {1'b0, i} + NW'(1);
    return (p >= n) ? '0 : p[AW-1:0];
  endfunction

  logic [cfsm_pkg::WordW-1:0] mem [DEPTH];
  logic [cfsm_pkg::WordW-1:0] rd_data_r;

  logic [NW-1:0]   n_r;
  logic [AW-1:0]   head_r, tail_r, ptr_r;
  logic            pend_r, first_r;
  cfsm_pkg::cmd_t  cmd_r;
  logic signed [cfsm_pkg::WordW-1:0] pv_r, key_r, data_r;
  logic              found_r;
  cfsm_pkg::status_t status_r;

  logic            empty, full, rd_en, scan_more;
  logic [AW-1:0]   raddr;

  assign empty     = (head_r == tail_r);
  assign full      = (advance(tail_r, n_r) == head_r);
  assign scan_more = (ptr_r != tail_r);
  assign rd_en     = ctl.pop_rd || ctl.head_rd || (ctl.scan_step && scan_more);
  assign raddr     = ctl.scan_step ? ptr_r : head_r;

  assign stat.cmd       = cmd_r;
  assign stat.empty     = empty;
  assign stat.full      = full;
  assign stat.scan_done = !scan_more && !pend_r;

  // ring storage, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (ctl.push_wr) mem[tail_r] <= pv_r;
    if (rd_en)       rd_data_r   <= mem[raddr];
  end

  // pointers and ring size
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r    <= clamp_size(cfsm_pkg::SlotsW'(cfsm_pkg::SlotsReset));
      head_r <= '0;
      tail_r <= '0;
      ptr_r  <= '0;
      pend_r <= 1'b0;
    end else if (cfg_we) begin
      n_r    <= clamp_size(cfg_data);
      head_r <= '0;
      tail_r <= '0;
    end else begin
      if (ctl.push_wr)  tail_r <= advance(tail_r, n_r);
      if (ctl.pop_take) head_r <= advance(head_r, n_r);
      if (ctl.scan_start) begin
        ptr_r  <= head_r;
        pend_r <= 1'b0;
      end else if (ctl.scan_step) begin
        pend_r <= scan_more;
        if (scan_more) ptr_r <= advance(ptr_r, n_r);
      end
    end
  end

  // per-word work registers
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_r <= cfsm_pkg::cmd_t'(in_cmd);
      pv_r  <= in_push_value;
      key_r <= in_search_key;
    end
    if (ctl.dispatch) begin
      data_r   <= '0;
      found_r  <= 1'b0;
      status_r <= ctl.status;
    end
    if (ctl.scan_start) first_r <= 1'b1;
    if (ctl.pop_take)   data_r  <= rd_data_r;
    if (ctl.scan_step && pend_r) begin
      first_r <= 1'b0;
      if (rd_data_r == key_r) found_r <= 1'b1;
      // running signed maximum, only kept for max
      if ((cmd_r == cfsm_pkg::CMD_MAX) &&
          (first_r || ($signed(rd_data_r) > data_r))) begin
        data_r <= rd_data_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_data_out   <= data_r;
      out_found      <= (cmd_r == cfsm_pkg::CMD_SEARCH) && found_r;
      out_head_value <= empty ? '0 : rd_data_r;
      out_is_empty   <= empty;
      out_is_full    <= full;
      out_status     <= status_r;
    end
  end

endmodule

[rtl/circular_fifo_with_search_max_core.sv]
// Ring-buffer queue of signed 32-bit words with push, pop, search and max,
// one result word per input word. Search and max walk the held entries
// through the single read port of the ring memory, one entry a cycle. A stalled
// output holds the block in its last state until the output register is free.
// One word is worked on at a time; the next is taken as soon as the previous
// result sits in the output register. Writing cfg_data sets the ring size
// (clamped to 2..DEPTH, capacity one less) and empties the queue; write it
// only while the block is idle.
module circular_fifo_with_search_max_core #(
  parameter int DEPTH = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [cfsm_pkg::SlotsW-1:0] cfg_data,
  cfsm_in_if.sink                     in_ch,
  cfsm_out_if.source                  out_ch
);

  cfsm_pkg::ctl_t     ctl;
  cfsm_pkg::dp_stat_t stat;

  cfsm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  cfsm_dp #(.DEPTH(DEPTH)) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .in_cmd         (in_ch.cmd),
    .in_push_value  (in_ch.push_value),
    .in_search_key  (in_ch.search_key),
    .ctl            (ctl),
    .stat           (stat),
    .out_data_out   (out_ch.data_out),
    .out_found      (out_ch.found),
    .out_head_value (out_ch.head_value),
    .out_is_empty   (out_ch.is_empty),
    .out_is_full    (out_ch.is_full),
    .out_status     (out_ch.status)
  );

endmodule

[rtl/cfsm_checker.sv]
module cfsm_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [cfsm_pkg::WordW-1:0] data_out,
  input logic signed [cfsm_pkg::WordW-1:0] head_value,
  input logic                              is_empty,
  input logic                              is_full,
  input logic [1:0]                        status
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && is_empty |-> head_value == '0)
    else $error("head value nonzero on empty queue");

  a_empty_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(is_empty && is_full))
    else $error("queue reported empty and full");

  a_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == cfsm_pkg::ST_OVERFLOW |-> is_full && data_out == '0)
    else $error("overflow without full queue");

  a_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == cfsm_pkg::ST_UNDERFLOW || status == cfsm_pkg::ST_MAX_EMPTY)
    |-> is_empty && data_out == '0)
    else $error("underflow or max on empty without empty queue");

endmodule

bind circular_fifo_with_search_max_core cfsm_checker u_cfsm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .data_out   (out_ch.data_out),
  .head_value (out_ch.head_value),
  .is_empty   (out_ch.is_empty),
  .is_full    (out_ch.is_full),
  .status     (out_ch.status)
);
